// ===== design/hw_queue_index_allocator_core_macros.svh =====
// Assertion macros used by the checker file.
`ifndef HW_QUEUE_INDEX_ALLOCATOR_CORE_MACROS_SVH
`define HW_QUEUE_INDEX_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define HQIA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hqia assertion failed");

// Next-cycle implication, ignored while reset is high.
`define HQIA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hqia assertion failed");

// Next-cycle implication that also holds through reset.
`define HQIA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("hqia assertion failed");

`endif

// ===== design/hqia_pkg.sv =====
package hqia_pkg;

  // Queue number map
  localparam int LAST_QUEUE   = 255;
  localparam int POOL1_LAST   = 127;
  localparam int POOL2_FIRST  = 128;
  localparam int POOL2_LAST   = 255;
  localparam int SLOT_COUNT   = 16;
  localparam int LOCAL_LIMIT  = 255;

  localparam int RAW_QUEUE    = 16;
  localparam int RETURN_QUEUE = 17;
  localparam int EVENT_QUEUE  = 18;
  localparam int FIRST_FREE   = 19;
  localparam int BLOCK_MASK   = 15;
  localparam int GROUP_MAX    = 16;

  // Skipped-number ring
  localparam int RING_DEPTH = 256;
  localparam int RING_AW    = $clog2(RING_DEPTH);
  localparam int CNT_W      = RING_AW + 1;

  // Field widths
  localparam int KIND_W = 3;
  localparam int ARG_W  = 5;
  localparam int QI_W   = 8;

  // Largest queue number any pointer can hold, then room for align plus a group
  localparam int NUM_MAX_A = (LAST_QUEUE > POOL1_LAST) ? LAST_QUEUE : POOL1_LAST;
  localparam int NUM_MAX_B = (POOL2_FIRST > POOL2_LAST) ? POOL2_FIRST : POOL2_LAST;
  localparam int NUM_MAX_C = (NUM_MAX_A > NUM_MAX_B) ? NUM_MAX_A : NUM_MAX_B;
  localparam int NUM_MAX   = (NUM_MAX_C > LOCAL_LIMIT) ? NUM_MAX_C : LOCAL_LIMIT;
  localparam int PTR_W     = $clog2(NUM_MAX + BLOCK_MASK + GROUP_MAX + 2);

  typedef enum logic [KIND_W-1:0] {
    KIND_CMD,
    KIND_LOCAL_FREE,
    KIND_GLOBAL_FREE,
    KIND_TRANSMIT,
    KIND_RAW,
    KIND_RETURN,
    KIND_EVENT,
    KIND_GROUP
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_PUSH,
    ST_DONE
  } state_t;

  // Ring memory access from the sequencer
  typedef struct packed {
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic               wr_en;
    logic [RING_AW-1:0] wr_addr;
    logic [QI_W-1:0]    wr_data;
  } ram_req_t;

  // Finished result handed to the output register
  typedef struct packed {
    logic            valid;
    logic [QI_W-1:0] queue_index;
    logic            failed;
  } res_t;

endpackage

// ===== design/hqia_ring_ram.sv =====
module hqia_ring_ram (
  input  logic                   clk,
  input  hqia_pkg::ram_req_t     req,
  output logic [hqia_pkg::QI_W-1:0] rd_data
);
  import hqia_pkg::*;

  logic [QI_W-1:0] mem [RING_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== design/hqia_ctrl.sv =====
module hqia_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  hqia_pkg::kind_t            in_kind,
  input  logic [hqia_pkg::ARG_W-1:0] in_arg,
  input  logic [hqia_pkg::QI_W-1:0]  ram_rd_data,
  output hqia_pkg::ram_req_t         ram,
  output hqia_pkg::res_t             res,
  input  logic                       res_ready
);
  import hqia_pkg::*;

  state_t state, state_next;

  logic [PTR_W-1:0]   pool1_next, pool1_next_next;
  logic [PTR_W-1:0]   pool2_next, pool2_next_next;
  logic [RING_AW-1:0] head, head_next;
  logic [CNT_W-1:0]   count, count_next;

  // Result being built
  logic [PTR_W-1:0] res_q, res_q_next;
  logic             res_none, res_none_next;
  logic             res_local, res_local_next;

  // Group reserve: numbers from push_cur up to push_end are skipped
  logic [PTR_W-1:0] push_cur, push_cur_next;
  logic [PTR_W-1:0] push_end, push_end_next;

  logic [PTR_W-1:0] arg_w;
  logic [PTR_W-1:0] aligned;
  logic [PTR_W-1:0] gap;
  logic [PTR_W-1:0] aligned_end;
  logic             take_free;
  logic             res_bad;

  // Block alignment for group reserve, and the free and transmit decode
  always_comb begin
    arg_w       = PTR_W'(in_arg);
    aligned     = (pool2_next + PTR_W'(BLOCK_MASK)) & ~PTR_W'(BLOCK_MASK);
    gap         = aligned - pool2_next;
    aligned_end = aligned + arg_w;
    take_free   = (in_kind == KIND_LOCAL_FREE) || (in_kind == KIND_GLOBAL_FREE) ||
                  ((in_kind == KIND_TRANSMIT) && (in_arg <= ARG_W'(1)));
  end

  // State and pointer registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pool1_next <= PTR_W'(FIRST_FREE);
      pool2_next <= PTR_W'(POOL2_FIRST);
      head       <= '0;
      count      <= '0;
    end else begin
      state      <= state_next;
      pool1_next <= pool1_next_next;
      pool2_next <= pool2_next_next;
      head       <= head_next;
      count      <= count_next;
    end
  end

  // Result and push cursor registers
  always_ff @(posedge clk) begin
    res_q     <= res_q_next;
    res_none  <= res_none_next;
    res_local <= res_local_next;
    push_cur  <= push_cur_next;
    push_end  <= push_end_next;
  end

  // Sequencer
  always_comb begin
    state_next      = state;
    pool1_next_next = pool1_next;
    pool2_next_next = pool2_next;
    head_next       = head;
    count_next      = count;
    res_q_next      = res_q;
    res_none_next   = res_none;
    res_local_next  = res_local;
    push_cur_next   = push_cur;
    push_end_next   = push_end;
    in_ready        = 1'b0;
    ram             = '0;

    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next     = ST_DONE;
          res_q_next     = '0;
          res_none_next  = 1'b1;
          res_local_next = 1'b0;
          case (in_kind)
            KIND_CMD: begin
              if ({1'b0, in_arg} < (ARG_W + 1)'(SLOT_COUNT)) begin
                res_q_next    = arg_w;
                res_none_next = 1'b0;
              end
            end
            KIND_RAW: begin
              res_q_next    = PTR_W'(RAW_QUEUE);
              res_none_next = 1'b0;
            end
            KIND_RETURN: begin
              res_q_next    = PTR_W'(RETURN_QUEUE);
              res_none_next = 1'b0;
            end
            KIND_EVENT: begin
              res_q_next    = PTR_W'(EVENT_QUEUE);
              res_none_next = 1'b0;
            end
            KIND_GROUP: begin
              if ({1'b0, in_arg} <= (ARG_W + 1)'(GROUP_MAX)) begin
                if (gap >= arg_w) begin
                  res_q_next      = pool2_next;
                  res_none_next   = 1'b0;
                  pool2_next_next = pool2_next + arg_w;
                end else if (aligned_end <= PTR_W'(LAST_QUEUE + 1)) begin
                  res_q_next      = aligned;
                  res_none_next   = 1'b0;
                  pool2_next_next = aligned_end;
                  push_cur_next   = pool2_next;
                  push_end_next   = aligned;
                  state_next      = ST_PUSH;
                end
              end
            end
            default: begin
              // Free kinds and transmit with arg up to 1: pool 1, then skipped ring, then pool 2
              if (take_free) begin
                res_local_next = (in_kind == KIND_LOCAL_FREE);
                if (pool1_next <= PTR_W'(POOL1_LAST)) begin
                  res_q_next      = pool1_next;
                  res_none_next   = 1'b0;
                  pool1_next_next = pool1_next + PTR_W'(1);
                end else if (count != '0) begin
                  ram.rd_en  = 1'b1;
                  ram.rd_addr = head;
                  head_next  = head + RING_AW'(1);
                  count_next = count - CNT_W'(1);
                  state_next = ST_READ;
                end else if (pool2_next < PTR_W'(POOL2_LAST)) begin
                  res_q_next      = pool2_next;
                  res_none_next   = 1'b0;
                  pool2_next_next = pool2_next + PTR_W'(1);
                end
              end
            end
          endcase
        end
      end

      ST_READ: begin
        // Ring data arrives in the cycle after the read
        res_q_next    = PTR_W'(ram_rd_data);
        res_none_next = 1'b0;
        state_next    = ST_DONE;
      end

      ST_PUSH: begin
        // One skipped number a cycle; dropped when the ring is full
        if (push_cur == push_end) begin
          state_next = ST_DONE;
        end else begin
          if (count < CNT_W'(RING_DEPTH)) begin
            ram.wr_en   = 1'b1;
            ram.wr_addr = head + count[RING_AW-1:0];
            ram.wr_data = push_cur[QI_W-1:0];
            count_next  = count + CNT_W'(1);
          end
          push_cur_next = push_cur + PTR_W'(1);
        end
      end

      ST_DONE: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Range checks on the finished number
  always_comb begin
    res_bad = res_none || (res_q > PTR_W'(LAST_QUEUE)) || (res_q > PTR_W'(255)) ||
              (res_local && (res_q > PTR_W'(LOCAL_LIMIT)));
    res.valid       = (state == ST_DONE);
    res.failed      = res_bad;
    res.queue_index = res_bad ? '0 : res_q[QI_W-1:0];
  end

endmodule

// ===== design/hw_queue_index_allocator_core.sv =====
// Fixed, command and pool requests: the result is registered in the sequencer and then
// in the output register; a number from the skipped ring also passes the ring's read
// register, and a group reserve that skips k numbers (k up to 15) first pushes them
// one by one through the ring's single write port. One request at a time; the next is
// accepted once the result has moved to the output register.
// Reset (rst, synchronous): pool pointers to their first numbers, ring emptied.
module hw_queue_index_allocator_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [2:0] kind, [7:3] arg
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] queue_index
  output logic       m_tuser    // [0] failed
);
  import hqia_pkg::*;

  ram_req_t        ram;
  res_t            res;
  logic [QI_W-1:0] ram_rd_data;
  logic            out_free;

  assign out_free = !m_tvalid || m_tready;

  hqia_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_kind     (kind_t'(s_tdata[KIND_W-1:0])),
    .in_arg      (s_tdata[KIND_W+ARG_W-1:KIND_W]),
    .ram_rd_data (ram_rd_data),
    .ram         (ram),
    .res         (res),
    .res_ready   (out_free)
  );

  hqia_ring_ram u_ring (
    .clk     (clk),
    .req     (ram),
    .rd_data (ram_rd_data)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res.valid) begin
      m_tdata <= res.queue_index;
      m_tuser <= res.failed;
    end
  end

endmodule

// ===== design/hqia_checker.sv =====
`include "hw_queue_index_allocator_core_macros.svh"

module hqia_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tuser
);

  // A failed result carries queue number zero
  `HQIA_ASSERT_NOW(a_fail_zero, clk, rst, m_tvalid && m_tuser, m_tdata == 8'd0)

  // A stalled result holds
  `HQIA_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // One request in flight: ready drops after each input transaction
  `HQIA_ASSERT_NEXT(a_one_inflight, clk, rst, s_tvalid && s_tready, !s_tready)

  // Output is empty after reset
  `HQIA_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !m_tvalid)

endmodule

bind hw_queue_index_allocator_core hqia_checker u_hqia_checker (.*);
